// ----- src/fbpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

    localparam int ADDR_W     = 32;
    localparam int UNIT_W     = 24;
    localparam int ALIGN_W    = 13;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;
    localparam int FC_W       = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 32;
    localparam int STRIDE_W   = 25;
    localparam int LAY_W      = 34;
    localparam int DIV_N      = 32;
    localparam int DIV_STEP_W = $clog2(DIV_N);

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [ST_W-1:0] ST_TRUNC    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_BYTES = 2'd3;

    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 13'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ST_W-1:0]   status;
        logic [FC_W-1:0]   count;
    } t_result;

endpackage

`default_nettype wire

// ----- src/fbpa_stack_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fbpa_stack_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/fbpa_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fbpa_div
    import fbpa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [DIV_N-1:0]    i_dividend,
    input  wire logic [STRIDE_W-1:0] i_divisor,
    output logic                     o_done,
    output logic      [DIV_N-1:0]    o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [STRIDE_W-1:0]   r_rem;
    logic [DIV_N-1:0]      r_quo;
    logic [STRIDE_W:0]     w_shift;
    logic                  w_bit;
    logic [STRIDE_W-1:0]   n_rem;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_shift = {r_rem, r_quo[DIV_N-1]};
        w_bit   = (w_shift >= {1'b0, i_divisor});
        n_rem   = w_bit ? STRIDE_W'(w_shift - {1'b0, i_divisor}) : w_shift[STRIDE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DIV_STEP_W'(DIV_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_N-2:0], w_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- src/fixed_block_pool_allocator_core.sv -----
// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_stall      i_op, i_user_addr
// output    out        o_out_valid / i_out_stall    o_result_addr, o_status, o_free_count
// config    in         i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// free, unknown op, empty allocate: answer at accept; allocate: stack ram read, then pop state
// init: four layout states, a 32-step divider, a saturate state, then one stack write per block
// reset clears stack depth, output valids and config (align to 4); stack ram is not cleared
// a new result that meets a stalled output goes to a hold register; input stalls while it is full
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS   = 1024,
    parameter int HEADER_BYTES = 72,
    parameter int LINK_BYTES   = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [ADDR_W-1:0]    i_user_addr,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [ADDR_W-1:0]    o_result_addr,
    output logic      [ST_W-1:0]      o_status,
    output logic      [FC_W-1:0]      o_free_count,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_POP  = 4'd1;
    localparam logic [3:0] S_LAY1 = 4'd2;
    localparam logic [3:0] S_LAY2 = 4'd3;
    localparam logic [3:0] S_LAY3 = 4'd4;
    localparam logic [3:0] S_LAY4 = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_SAT  = 4'd7;
    localparam logic [3:0] S_FILL = 4'd8;

    logic [ADDR_W-1:0]   r_heap_base;
    logic [ADDR_W-1:0]   r_heap_size;
    logic [UNIT_W-1:0]   r_unit_size;
    logic [ALIGN_W-1:0]  r_align_bytes;

    logic [3:0]          r_state, n_state;
    logic [CW-1:0]       r_depth, n_depth;
    logic [STRIDE_W-1:0] r_stride, n_stride;
    logic [LAY_W-1:0]    r_wide, n_wide;
    logic [ADDR_W-1:0]   r_faddr, n_faddr;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [AW-1:0]       r_idx, n_idx;
    logic [ST_W-1:0]     r_ist, n_ist;

    t_result             r_out, r_hold;
    logic                r_ov, r_hv;

    logic                w_accept;
    logic                w_out_free;
    logic [ALIGN_W-1:0]  w_m;
    logic                done_v;
    t_result             done_r;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_addr;
    logic [ADDR_W-1:0]   ram_wdata, ram_rdata;
    logic                div_start, div_done;
    logic [ADDR_W-1:0]   div_dividend, div_quo;

    assign o_in_stall = (r_state != S_IDLE) || r_hv;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_m        = (r_align_bytes == '0) ? '0 : r_align_bytes - 1'b1;

    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_stride     = r_stride;
        n_wide       = r_wide;
        n_faddr      = r_faddr;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_ist        = r_ist;
        done_v       = 1'b0;
        done_r       = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = AW'(r_depth);
        ram_wdata    = i_user_addr - ADDR_W'(LINK_BYTES);
        div_start    = 1'b0;
        div_dividend = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        OP_INIT: begin
                            n_state = S_LAY1;
                        end
                        OP_ALLOC: begin
                            if (r_depth == '0) begin
                                done_v        = 1'b1;
                                done_r.status = ST_EMPTY;
                                done_r.count  = FC_W'(r_depth);
                            end else begin
                                ram_re   = 1'b1;
                                ram_addr = AW'(r_depth - 1'b1);
                                n_depth  = r_depth - 1'b1;
                                n_state  = S_POP;
                            end
                        end
                        OP_FREE: begin
                            done_v = 1'b1;
                            if (r_depth >= CW'(MAX_BLOCKS)) begin
                                done_r.status = ST_OVERFLOW;
                                done_r.count  = FC_W'(r_depth);
                            end else begin
                                ram_we        = 1'b1;
                                n_depth       = r_depth + 1'b1;
                                done_r.status = ST_OK;
                                done_r.count  = FC_W'(r_depth + 1'b1);
                            end
                        end
                        default: begin
                            done_v        = 1'b1;
                            done_r.status = ST_OK;
                            done_r.count  = FC_W'(r_depth);
                        end
                    endcase
                end
            end
            S_POP: begin
                done_v        = 1'b1;
                done_r.addr   = ram_rdata + ADDR_W'(LINK_BYTES);
                done_r.status = ST_OK;
                done_r.count  = FC_W'(r_depth);
                n_state       = S_IDLE;
            end
            S_LAY1: begin
                n_stride = (STRIDE_W'(r_unit_size) + STRIDE_W'(LINK_BYTES) + STRIDE_W'(w_m))
                           & ~STRIDE_W'(w_m);
                n_wide   = LAY_W'(r_heap_base) + LAY_W'(HEADER_BYTES) + LAY_W'(LINK_BYTES)
                           + LAY_W'(w_m);
                n_state  = S_LAY2;
            end
            S_LAY2: begin
                // first block address
                n_wide  = (r_wide & ~LAY_W'(w_m)) - LAY_W'(LINK_BYTES);
                n_state = S_LAY3;
            end
            S_LAY3: begin
                n_faddr = r_wide[ADDR_W-1:0];
                n_wide  = r_wide - LAY_W'(r_heap_base);
                n_state = S_LAY4;
            end
            S_LAY4: begin
                div_start    = 1'b1;
                div_dividend = (r_wide <= LAY_W'(r_heap_size))
                               ? r_heap_size - r_wide[ADDR_W-1:0] : '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                if (div_quo > ADDR_W'(MAX_BLOCKS)) begin
                    n_cnt = CW'(MAX_BLOCKS);
                    n_ist = ST_TRUNC;
                end else begin
                    n_cnt = CW'(div_quo);
                    n_ist = ST_OK;
                end
                n_idx   = AW'(n_cnt - 1'b1);
                n_state = S_FILL;
            end
            S_FILL: begin
                // lowest block ends on top of the stack
                if (r_cnt != '0) begin
                    ram_we    = 1'b1;
                    ram_addr  = r_idx;
                    ram_wdata = r_faddr;
                    n_faddr   = r_faddr + ADDR_W'(r_stride);
                    n_idx     = r_idx - 1'b1;
                end
                if (r_cnt == '0 || r_idx == '0) begin
                    done_v        = 1'b1;
                    done_r.status = r_ist;
                    done_r.count  = FC_W'(r_cnt);
                    n_depth       = r_cnt;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_depth       <= '0;
            r_heap_base   <= '0;
            r_heap_size   <= '0;
            r_unit_size   <= '0;
            r_align_bytes <= ALIGN_RESET;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HEAP_BASE:   r_heap_base   <= i_cfg_data[ADDR_W-1:0];
                    REG_HEAP_SIZE:   r_heap_size   <= i_cfg_data[ADDR_W-1:0];
                    REG_UNIT_SIZE:   r_unit_size   <= i_cfg_data[UNIT_W-1:0];
                    REG_ALIGN_BYTES: r_align_bytes <= i_cfg_data[ALIGN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stride <= n_stride;
        r_wide   <= n_wide;
        r_faddr  <= n_faddr;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_ist    <= n_ist;
    end

    // output register with a hold stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_hv <= 1'b0;
        end else if (w_out_free) begin
            if (r_hv) begin
                r_ov <= 1'b1;
                r_hv <= done_v;
            end else begin
                r_ov <= done_v;
            end
        end else if (done_v) begin
            r_hv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_hv) begin
                r_out  <= r_hold;
                r_hold <= done_r;
            end else begin
                r_out <= done_r;
            end
        end else if (done_v) begin
            r_hold <= done_r;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_result_addr = r_out.addr;
    assign o_status      = r_out.status;
    assign o_free_count  = r_out.count;

    fbpa_stack_ram #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW),
        .DW    (ADDR_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_stride),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

endmodule

`default_nettype wire

// ----- src/fbpa_check.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fbpa_check
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [ADDR_W-1:0] o_result_addr,
    input wire logic [ST_W-1:0]   o_status,
    input wire logic [FC_W-1:0]   o_free_count
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_addr)
            && $stable(o_status) && $stable(o_free_count))
        else $error("stalled output word changed");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_free_count == '0 && o_result_addr == '0)
        else $error("empty pool word with nonzero count or address");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OVERFLOW |->
            o_free_count == FC_W'(MAX_BLOCKS) && o_result_addr == '0)
        else $error("overflow word while stack not full");

    a_addr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_addr != '0 |-> o_status == ST_OK)
        else $error("address returned with error status");

endmodule

bind fixed_block_pool_allocator_core fbpa_check #(
    .MAX_BLOCKS (MAX_BLOCKS)
) u_fbpa_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_addr (o_result_addr),
    .o_status      (o_status),
    .o_free_count  (o_free_count)
);

`default_nettype wire
